// ----- rtl/mmps_pkg.sv -----
// ----------------------------------------------------------------------------
// mmps_pkg
// Shared types and constants for the min/max priority set: field widths,
// operation codes and status codes.
// ----------------------------------------------------------------------------
package mmps_pkg;

   localparam int CAPACITY_DEFAULT = 1024;
   localparam int OP_W             = 2;
   localparam int KEY_W            = 32;
   localparam int VALUE_W          = 32;
   localparam int COUNT_W          = 11;
   localparam int SUM_W            = 42;
   localparam int ENTRY_W          = KEY_W + VALUE_W;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT     = 2'd0,
      OP_REMOVE_MIN = 2'd1,
      OP_REMOVE_MAX = 2'd2,
      OP_NONE       = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_DUP   = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

endpackage

// ----- rtl/mmps_ram.sv -----
// ----------------------------------------------------------------------------
// mmps_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mmps_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/mmps_idx_map.sv -----
// ----------------------------------------------------------------------------
// mmps_idx_map
// Shared index unit: maps a logical position in the ordered ring to a
// physical RAM address, (head + position) modulo the capacity.
// ----------------------------------------------------------------------------
module mmps_idx_map #(
   parameter int CAPACITY = mmps_pkg::CAPACITY_DEFAULT
) (
   input  logic [$clog2(CAPACITY)-1:0] head,
   input  logic [$clog2(CAPACITY)-1:0] lidx,
   output logic [$clog2(CAPACITY)-1:0] phys
);

   localparam int AW = $clog2(CAPACITY);

   logic [AW:0] sum;

   // add, then fold back once: both operands stay below the capacity
   always_comb begin
      sum = {1'b0, head} + {1'b0, lidx};
      if (sum >= (AW+1)'(CAPACITY)) begin
         sum = sum - (AW+1)'(CAPACITY);
      end
      phys = sum[AW-1:0];
   end

endmodule

// ----- rtl/min_max_priority_set.sv -----
// ----------------------------------------------------------------------------
// min_max_priority_set
// Bounded ordered set of unique-key pairs with insert, remove-min and
// remove-max, reporting count and running key/value sums on every beat.
// ----------------------------------------------------------------------------
// Pairs live in one RAM as a ring kept in ascending key order; a head pointer
// marks the smallest key. All work runs through the RAM, whose read and write
// ports share one address, under a small sequencer, one item at a time, and
// req_stall stays high from accept until the result is loaded into the output
// register. An insert runs a binary search (at most ceil(log2(n+1)) probes for
// n entries), then moves each entry above the insertion point up one slot,
// then writes the new pair; remove-min and remove-max read the end entry and
// drop it. A duplicate insert ends on its matching probe and a full insert once
// the search has settled; an empty remove and the unused code go straight to
// the finish. Every item waits there while the output register is stalled.
// The RAM needs no clearing after reset: only positions below the entry count
// are ever read.
// ----------------------------------------------------------------------------
module min_max_priority_set #(
   parameter int CAPACITY = mmps_pkg::CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_item_key,
   input  logic [31:0] req_item_value,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_removed_valid,
   output logic [31:0] rsp_removed_key,
   output logic [31:0] rsp_removed_value,
   output logic [10:0] rsp_entry_count,
   output logic [41:0] rsp_key_total,
   output logic [41:0] rsp_value_total
);

   localparam int AW      = $clog2(CAPACITY);
   localparam int CW      = $clog2(CAPACITY + 1);
   localparam int KEY_W   = mmps_pkg::KEY_W;
   localparam int VALUE_W = mmps_pkg::VALUE_W;
   localparam int ENTRY_W = mmps_pkg::ENTRY_W;
   localparam int SUM_W   = mmps_pkg::SUM_W;
   localparam int CNT_W   = mmps_pkg::COUNT_W;

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_SRCH_ISS = 9'b000000010,
      S_SRCH_CMP = 9'b000000100,
      S_SHIFT_RD = 9'b000001000,
      S_SHIFT_WR = 9'b000010000,
      S_PLACE    = 9'b000100000,
      S_REM_RD   = 9'b001000000,
      S_REM_DATA = 9'b010000000,
      S_FINISH   = 9'b100000000
   } state_type;

   state_type              state_ff, state_in;
   mmps_pkg::op_type       op_ff, op_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [VALUE_W-1:0]     value_ff, value_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          head_ff, head_in;
   logic [SUM_W-1:0]       key_sum_ff, key_sum_in;
   logic [SUM_W-1:0]       value_sum_ff, value_sum_in;
   logic [CW-1:0]          lo_ff, lo_in;
   logic [CW-1:0]          hi_ff, hi_in;
   logic [AW-1:0]          idx_ff, idx_in;
   mmps_pkg::status_type   status_ff, status_in;
   logic                   rem_valid_ff, rem_valid_in;
   logic [KEY_W-1:0]       rem_key_ff, rem_key_in;
   logic [VALUE_W-1:0]     rem_value_ff, rem_value_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   mmps_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic                   rsp_rvalid_ff, rsp_rvalid_in;
   logic [KEY_W-1:0]       rsp_rkey_ff, rsp_rkey_in;
   logic [VALUE_W-1:0]     rsp_rvalue_ff, rsp_rvalue_in;
   logic [CNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic [SUM_W-1:0]       rsp_ksum_ff, rsp_ksum_in;
   logic [SUM_W-1:0]       rsp_vsum_ff, rsp_vsum_in;

   logic                   mem_wr_en;
   logic                   mem_rd_en;
   logic [ENTRY_W-1:0]     mem_wr_data;
   logic [ENTRY_W-1:0]     mem_rd_data;
   logic [AW-1:0]          map_lidx;
   logic [AW-1:0]          map_phys;
   logic [KEY_W-1:0]       rd_key;
   logic [VALUE_W-1:0]     rd_value;
   logic [CW:0]            mid_sum;
   logic [CW-1:0]          mid;
   logic                   req_beat;

   assign req_stall = (state_ff != S_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign rd_key    = mem_rd_data[ENTRY_W-1:VALUE_W];
   assign rd_value  = mem_rd_data[VALUE_W-1:0];
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = mid_sum[CW:1];

   // ordered storage
   mmps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_mmps_ram (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (map_phys),
      .wr_data    (mem_wr_data),
      .rd_en      (mem_rd_en),
      .rd_addr    (map_phys),
      .rd_data_ff (mem_rd_data)
   );

   // shared ring index unit
   mmps_idx_map #(
      .CAPACITY (CAPACITY)
   ) u_mmps_idx_map (
      .head (head_ff),
      .lidx (map_lidx),
      .phys (map_phys)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      key_sum_in   = key_sum_ff;
      value_sum_in = value_sum_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      rem_valid_in = rem_valid_ff;
      rem_key_in   = rem_key_ff;
      rem_value_in = rem_value_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      mem_wr_data  = mem_rd_data;
      map_lidx     = idx_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_rvalid_in = rsp_rvalid_ff;
      rsp_rkey_in   = rsp_rkey_ff;
      rsp_rvalue_in = rsp_rvalue_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_ksum_in   = rsp_ksum_ff;
      rsp_vsum_in   = rsp_vsum_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               op_in        = mmps_pkg::op_type'(req_operation);
               key_in       = req_item_key;
               value_in     = req_item_value;
               lo_in        = '0;
               hi_in        = count_ff;
               status_in    = mmps_pkg::STATUS_DONE;
               rem_valid_in = 1'b0;
               rem_key_in   = '0;
               rem_value_in = '0;
               unique case (mmps_pkg::op_type'(req_operation))
                  mmps_pkg::OP_INSERT: begin
                     state_in = S_SRCH_ISS;
                  end
                  mmps_pkg::OP_REMOVE_MIN, mmps_pkg::OP_REMOVE_MAX: begin
                     if (count_ff == '0) begin
                        status_in = mmps_pkg::STATUS_EMPTY;
                        state_in  = S_FINISH;
                     end else begin
                        state_in  = S_REM_RD;
                     end
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end

         // probe the middle of the open range, or settle the insert
         S_SRCH_ISS: begin
            map_lidx = mid[AW-1:0];
            if (lo_ff < hi_ff) begin
               mem_rd_en = 1'b1;
               state_in  = S_SRCH_CMP;
            end else if (count_ff >= CW'(CAPACITY)) begin
               status_in = mmps_pkg::STATUS_FULL;
               state_in  = S_FINISH;
            end else begin
               idx_in = count_ff[AW-1:0];
               if (count_ff == lo_ff) begin
                  state_in = S_PLACE;
               end else begin
                  state_in = S_SHIFT_RD;
               end
            end
         end

         // narrow the range; stop on a matching key
         S_SRCH_CMP: begin
            if (rd_key == key_ff) begin
               status_in = mmps_pkg::STATUS_DUP;
               state_in  = S_FINISH;
            end else begin
               if (rd_key < key_ff) begin
                  lo_in = mid + CW'(1);
               end else begin
                  hi_in = mid;
               end
               state_in = S_SRCH_ISS;
            end
         end

         // move one entry up one slot
         S_SHIFT_RD: begin
            map_lidx  = idx_ff - AW'(1);
            mem_rd_en = 1'b1;
            state_in  = S_SHIFT_WR;
         end

         S_SHIFT_WR: begin
            map_lidx    = idx_ff;
            mem_wr_en   = 1'b1;
            mem_wr_data = mem_rd_data;
            idx_in      = idx_ff - AW'(1);
            if (CW'(idx_ff - AW'(1)) == lo_ff) begin
               state_in = S_PLACE;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end

         // write the new pair into the gap
         S_PLACE: begin
            map_lidx     = lo_ff[AW-1:0];
            mem_wr_en    = 1'b1;
            mem_wr_data  = {key_ff, value_ff};
            count_in     = count_ff + CW'(1);
            key_sum_in   = key_sum_ff + SUM_W'(key_ff);
            value_sum_in = value_sum_ff + SUM_W'(value_ff);
            state_in     = S_FINISH;
         end

         // fetch the smallest or largest entry
         S_REM_RD: begin
            if (op_ff == mmps_pkg::OP_REMOVE_MIN) begin
               map_lidx = '0;
            end else begin
               map_lidx = AW'(count_ff - CW'(1));
            end
            mem_rd_en = 1'b1;
            state_in  = S_REM_DATA;
         end

         // drop the entry; advance head past it for a remove-min
         S_REM_DATA: begin
            map_lidx     = AW'(1);
            rem_valid_in = 1'b1;
            rem_key_in   = rd_key;
            rem_value_in = rd_value;
            count_in     = count_ff - CW'(1);
            key_sum_in   = key_sum_ff - SUM_W'(rd_key);
            value_sum_in = value_sum_ff - SUM_W'(rd_value);
            if (op_ff == mmps_pkg::OP_REMOVE_MIN) begin
               head_in = map_phys;
            end
            state_in = S_FINISH;
         end

         // hold until the output register is free, then load the beat
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_rvalid_in = rem_valid_ff;
               rsp_rkey_in   = rem_key_ff;
               rsp_rvalue_in = rem_value_ff;
               rsp_count_in  = CNT_W'(count_ff);
               rsp_ksum_in   = key_sum_ff;
               rsp_vsum_in   = value_sum_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         key_sum_ff   <= '0;
         value_sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         key_sum_ff   <= key_sum_in;
         value_sum_ff <= value_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and output payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      rem_valid_ff  <= rem_valid_in;
      rem_key_ff    <= rem_key_in;
      rem_value_ff  <= rem_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rvalid_ff <= rsp_rvalid_in;
      rsp_rkey_ff   <= rsp_rkey_in;
      rsp_rvalue_ff <= rsp_rvalue_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_ksum_ff   <= rsp_ksum_in;
      rsp_vsum_ff   <= rsp_vsum_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_valid = rsp_rvalid_ff;
   assign rsp_removed_key   = rsp_rkey_ff;
   assign rsp_removed_value = rsp_rvalue_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_key_total     = rsp_ksum_ff;
   assign rsp_value_total   = rsp_vsum_ff;

endmodule

// ----- rtl/mmps_checker.sv -----
// ----------------------------------------------------------------------------
// mmps_checker
// Port-level checks on the min/max priority set, bound to the top level.
// ----------------------------------------------------------------------------
module mmps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_operation,
   input logic [31:0] req_item_key,
   input logic [31:0] req_item_value,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic        rsp_removed_valid,
   input logic [31:0] rsp_removed_key,
   input logic [31:0] rsp_removed_value,
   input logic [10:0] rsp_entry_count,
   input logic [41:0] rsp_key_total,
   input logic [41:0] rsp_value_total
);

   // a beat without a removal carries zero key and value
   a_no_removal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_removed_valid |-> rsp_removed_key == 32'd0 &&
      rsp_removed_value == 32'd0)
      else $error("removed fields nonzero without a removal");

   // an ignored empty remove reports an empty set and removes nothing
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mmps_pkg::STATUS_EMPTY |->
      rsp_entry_count == 11'd0 && !rsp_removed_valid)
      else $error("empty status with entries or a removal");

   // one item at a time: an accepted beat stalls the next
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while an item is in work");

   // a stalled request beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_operation) &&
      $stable(req_item_key) && $stable(req_item_value))
      else $error("stalled request beat changed");

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_removed_valid) && $stable(rsp_removed_key) &&
      $stable(rsp_removed_value) && $stable(rsp_entry_count) &&
      $stable(rsp_key_total) && $stable(rsp_value_total))
      else $error("stalled response beat changed");

endmodule

bind min_max_priority_set mmps_checker u_mmps_checker (.*);
